FILE: rtl/ptfm_pkg.sv
`default_nettype none
package ptfm_pkg;

  // Timer behaviour selected by the mode register.
  typedef enum logic [2:0] {
    MODE_PULSE        = 3'd0,
    MODE_EXT_PULSE    = 3'd1,
    MODE_ON_DELAY     = 3'd2,
    MODE_RET_ON_DELAY = 3'd3,
    MODE_OFF_DELAY    = 3'd4
  } timer_mode_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESET_TICKS = 2'd1;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned PRESET_W = 32;
  localparam int unsigned BYTE_W   = 8;

  // Levels carried by one tick.
  typedef struct packed {
    logic set_level;
    logic clear_level;
  } tick_levels_t;

endpackage
`default_nettype wire

FILE: rtl/ptfm_tick.sv
`default_nettype none
module ptfm_tick #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  ptfm_pkg::tick_levels_t  levels,
  input  logic [2:0]              timer_mode,
  input  logic [31:0]             preset_ticks,
  input  logic                    running,
  input  logic [TIME_WIDTH-1:0]   elapsed,
  output logic                    running_nxt,
  output logic [TIME_WIDTH-1:0]   elapsed_nxt,
  output logic                    q_out
);
  import ptfm_pkg::*;

  localparam int unsigned CMP_W = (TIME_WIDTH > PRESET_W) ? TIME_WIDTH : PRESET_W;

  logic [TIME_WIDTH-1:0] elapsed_inc;
  logic [TIME_WIDTH-1:0] elapsed_start;
  logic                  in_time_inc;
  logic                  in_time_start;
  logic                  do_start;

  // Saturating increment of the elapsed counter.
  assign elapsed_inc = (elapsed == {TIME_WIDTH{1'b1}}) ? elapsed
                                                      : elapsed + {{(TIME_WIDTH-1){1'b0}}, 1'b1};

  // In-time test both for the counted value and for a fresh start at zero.
  assign in_time_inc   = CMP_W'(elapsed_inc) < CMP_W'(preset_ticks);
  assign in_time_start = preset_ticks != '0;

  // Decide whether this tick starts the timer.
  always_comb begin
    do_start = 1'b0;
    unique case (timer_mode)
      MODE_PULSE:        do_start = levels.set_level && !levels.clear_level && !running;
      MODE_EXT_PULSE,
      MODE_ON_DELAY,
      MODE_RET_ON_DELAY: do_start = levels.set_level && !levels.clear_level && !running;
      MODE_OFF_DELAY:    do_start = levels.set_level && !levels.clear_level;
      default:           do_start = 1'b0;
    endcase
  end

  assign elapsed_start = '0;
  assign elapsed_nxt   = do_start ? elapsed_start : elapsed_inc;

  // Running flag and output level for this tick.
  always_comb begin
    logic run_v;
    logic in_time;
    run_v   = running || do_start;
    in_time = do_start ? in_time_start : in_time_inc;
    running_nxt = 1'b0;
    q_out       = 1'b0;
    unique case (timer_mode)
      MODE_PULSE: begin
        if (levels.set_level && !levels.clear_level) begin
          running_nxt = run_v;
          q_out       = run_v && in_time;
        end
      end
      MODE_EXT_PULSE: begin
        if (!levels.clear_level) begin
          if (in_time) begin
            running_nxt = run_v;
            q_out       = run_v;
          end else begin
            running_nxt = run_v && levels.set_level;
          end
        end
      end
      MODE_ON_DELAY: begin
        if (!levels.clear_level) begin
          if (in_time) begin
            running_nxt = run_v;
          end else begin
            running_nxt = run_v && levels.set_level;
            q_out       = run_v && levels.set_level;
          end
        end
      end
      MODE_RET_ON_DELAY: begin
        if (!levels.clear_level) begin
          running_nxt = run_v;
          q_out       = run_v && !in_time;
        end
      end
      MODE_OFF_DELAY: begin
        if (!levels.clear_level && in_time) begin
          running_nxt = run_v;
          q_out       = run_v;
        end
      end
      default: begin
        running_nxt = 1'b0;
        q_out       = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/plc_timer_five_modes_core.sv
`default_nettype none
// An accepted tick's result is registered and shows on out_tdata the cycle after.
// Throughput: one tick per cycle while out_tready does not stall a pending result;
// elapsed update and preset compare are done in the cycle the output register closes.
// Reset (rst_n low, synchronous): timer idle, elapsed counter saturated at all ones,
// mode pulse, preset zero, no result pending.
module plc_timer_five_modes_core #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // bit 0 set_level, bit 1 clear_level, bits 7:2 zero
  input  wire logic [ptfm_pkg::BYTE_W-1:0]     in_tdata,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // bit 0 q_out, bits 7:1 zero
  output logic [ptfm_pkg::BYTE_W-1:0]          out_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ptfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ptfm_pkg::PRESET_W-1:0]   cfg_data
);
  import ptfm_pkg::*;

  logic [MODE_W-1:0]     timer_mode_r;
  logic [PRESET_W-1:0]   preset_ticks_r;
  logic                  running_r;
  logic [TIME_WIDTH-1:0] elapsed_r;
  logic                  out_valid_r;
  logic                  q_out_r;

  logic                  running_nxt;
  logic [TIME_WIDTH-1:0] elapsed_nxt;
  logic                  q_nxt;
  logic                  in_fire;
  tick_levels_t          levels;

  assign levels.set_level   = in_tdata[0];
  assign levels.clear_level = in_tdata[1];

  // The output register frees itself in the cycle its transaction is taken.
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  ptfm_tick #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_tick (
    .levels       (levels),
    .timer_mode   (timer_mode_r),
    .preset_ticks (preset_ticks_r),
    .running      (running_r),
    .elapsed      (elapsed_r),
    .running_nxt  (running_nxt),
    .elapsed_nxt  (elapsed_nxt),
    .q_out        (q_nxt)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_mode_r   <= MODE_W'(MODE_PULSE);
      preset_ticks_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_TIMER_MODE) begin
        timer_mode_r <= cfg_data[MODE_W-1:0];
      end else if (cfg_index == REG_PRESET_TICKS) begin
        preset_ticks_r <= cfg_data;
      end
    end
  end

  // Timer state advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      elapsed_r <= {TIME_WIDTH{1'b1}};
    end else if (in_fire) begin
      running_r <= running_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  // Result register and its valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      q_out_r <= q_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(BYTE_W-1){1'b0}}, q_out_r};

endmodule
`default_nettype wire

FILE: test/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptfm_pkg::*;

  localparam int unsigned WIDTH      = 32;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned RAND_TICKS = 550;

  // Tracks the timer state and the output levels still to come back.
  class timer_tracker;
    logic [MODE_W-1:0]   mode;
    logic [PRESET_W-1:0] preset;
    logic                running;
    logic [WIDTH-1:0]    elapsed;
    logic                q_expected[$];
    int                  mismatches;

    function new();
      mode       = MODE_PULSE;
      preset     = '0;
      running    = 1'b0;
      elapsed    = '1;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PRESET_W-1:0] data);
      if (idx == REG_TIMER_MODE) begin
        mode = data[MODE_W-1:0];
      end else if (idx == REG_PRESET_TICKS) begin
        preset = data;
      end
    endfunction

    // Advances the timer by one tick and queues the level it should produce.
    function void note_tick(logic set_lvl, logic clr_lvl);
      logic q;
      q = 1'b0;
      if (elapsed != '1) elapsed = elapsed + 1'b1;
      case (mode)
        MODE_PULSE: begin
          if (!set_lvl || clr_lvl) begin
            running = 1'b0;
          end else begin
            if (!running) begin
              running = 1'b1;
              elapsed = '0;
            end
            q = running && (elapsed < preset);
          end
        end
        MODE_EXT_PULSE: begin
          if (clr_lvl) begin
            running = 1'b0;
          end else begin
            if (set_lvl && !running) begin
              running = 1'b1;
              elapsed = '0;
            end
            if (elapsed < preset) q = running;
            else if (!set_lvl) running = 1'b0;
          end
        end
        MODE_ON_DELAY, MODE_RET_ON_DELAY: begin
          if (clr_lvl) begin
            running = 1'b0;
          end else begin
            if (set_lvl && !running) begin
              running = 1'b1;
              elapsed = '0;
            end
            if (!(elapsed < preset)) begin
              // Only the plain on-delay drops out when set goes low.
              if (mode == MODE_ON_DELAY && !set_lvl) running = 1'b0;
              q = running;
            end
          end
        end
        MODE_OFF_DELAY: begin
          if (clr_lvl) begin
            running = 1'b0;
          end else begin
            // Every set tick restarts the off-delay.
            if (set_lvl) begin
              running = 1'b1;
              elapsed = '0;
            end
            if (elapsed < preset) q = running;
            else running = 1'b0;
          end
        end
        default: begin
          running = 1'b0;
        end
      endcase
      q_expected.push_back(q);
    endfunction

    function void check_q(logic [BYTE_W-1:0] data);
      logic want;
      if (q_expected.size() == 0) begin
        $error("q_out: no transaction expected, got %0b", data[0]);
        mismatches++;
      end else begin
        want = q_expected.pop_front();
        if (data[0] !== want) begin
          $error("q_out: expected %0b, got %0b", want, data[0]);
          mismatches++;
        end
      end
    endfunction

    function int outstanding();
      return q_expected.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic [BYTE_W-1:0]     in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [BYTE_W-1:0]     out_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [PRESET_W-1:0]   cfg_data;

  timer_tracker tracker = new();
  int           burst_left;
  int unsigned  idle_cycles;
  logic [7:0]   stall_ctr;

  plc_timer_five_modes_core #(.TIME_WIDTH(WIDTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Transactions seen at each edge feed the tracker; input first so that a
  // same-edge result would still find its expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) tracker.note_tick(in_tdata[0], in_tdata[1]);
      if (out_tvalid && out_tready) tracker.check_q(out_tdata);
    end
  end

  // The result side cycles through always ready, random, sparse and long stalls.
  always @(posedge clk) begin
    stall_ctr <= stall_ctr + 1'b1;
    case (stall_ctr[7:6])
      2'd0: begin
        out_tready <= 1'b1;
      end
      2'd1: begin
        out_tready <= 1'($urandom_range(0, 1));
      end
      2'd2: begin
        out_tready <= (stall_ctr[2:0] == 3'd0);
      end
      default: begin
        out_tready <= (stall_ctr[5:4] != 2'd0);
      end
    endcase
  end

  // Ends the run if no channel has moved a transaction for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offers one tick and holds it until accepted; may then pause between bursts.
  task automatic send_tick(input logic set_lvl, input logic clr_lvl);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, clr_lvl, set_lvl};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  // Lets every outstanding tick come back so that the block is idle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  // Writes one register and then leaves the channel idle.
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [PRESET_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_timer(input logic [PRESET_W-1:0] mode_word,
                           input logic [PRESET_W-1:0] preset);
    wait_idle();
    write_cfg(REG_TIMER_MODE, mode_word);
    write_cfg(REG_PRESET_TICKS, preset);
  endtask

  // Sends n ticks; bit i of each mask gives the levels of tick i.
  task automatic run_ticks(input logic [15:0] sets, input logic [15:0] clrs, input int n);
    for (int i = 0; i < n; i++) send_tick(sets[i], clrs[i]);
  endtask

  function automatic logic [PRESET_W-1:0] pick_preset();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return 32'd1;
      2:       return '1;
      3:       return $urandom();
      default: return $urandom_range(2, 14);
    endcase
  endfunction

  initial begin
    int            sent;
    int            len;
    int            hold;
    logic          lvl;
    logic          clr_lvl;
    logic [PRESET_W-1:0] mode_word;

    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    out_tready <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_TIMER_MODE;
    cfg_data   <= '0;
    stall_ctr  <= '0;
    idle_cycles <= 0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: pulse with zero preset never drives the output.
    run_ticks(16'b11, 16'b10, 2);
    // Pulse held past its preset, then released.
    set_timer(MODE_PULSE, 32'd2);
    run_ticks(16'b0111, 16'b0000, 4);
    // Extended pulse runs on after a single trigger tick.
    set_timer(MODE_EXT_PULSE, 32'd2);
    run_ticks(16'b0001, 16'b0000, 4);
    // On-delay with set held, cleared while set is still high.
    set_timer(MODE_ON_DELAY, 32'd1);
    run_ticks(16'b1111, 16'b1000, 4);
    // Retentive on-delay keeps running without set until cleared.
    set_timer(MODE_RET_ON_DELAY, 32'd2);
    run_ticks(16'b00001, 16'b10000, 5);
    // Off-delay with the largest preset never times out.
    set_timer(MODE_OFF_DELAY, '1);
    run_ticks(16'b001, 16'b100, 3);
    // An all-ones mode word masks down to an unused mode.
    set_timer('1, '0);
    run_ticks(16'b11, 16'b00, 2);

    // Random phases; each may reconfigure without clearing, so a running
    // timer can be carried over into the new mode.
    sent = 0;
    while (sent < RAND_TICKS) begin
      wait_idle();
      if ($urandom_range(0, 3) != 0) begin
        mode_word = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 7)
                                                 : $urandom_range(0, 4);
        write_cfg(REG_TIMER_MODE, mode_word);
      end
      if ($urandom_range(0, 3) != 0) write_cfg(REG_PRESET_TICKS, pick_preset());
      len  = $urandom_range(8, 48);
      hold = 0;
      lvl  = 1'b0;
      for (int i = 0; i < len; i++) begin
        // Set is held in runs, so that presets are reached and passed.
        if (hold == 0) begin
          lvl  = ~lvl;
          hold = lvl ? $urandom_range(1, 16) : $urandom_range(1, 10);
        end
        hold--;
        clr_lvl = ($urandom_range(0, 11) == 0);
        if ($urandom_range(0, 9) == 0) send_tick(1'($urandom_range(0, 1)), clr_lvl);
        else send_tick(lvl, clr_lvl);
        sent++;
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
